// ----- hw/rtl/bpa_pkg.sv -----
// shared types, sizes and codes of the buddy page allocator
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int NUM_PAGES = 32768;
  localparam int PAGE_W    = 15;
  localparam int ORD_W     = 4;
  localparam int TOP_ORDER = 11;
  localparam int LISTS     = TOP_ORDER + 1;
  localparam int CNT_W     = PAGE_W + 1;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [ORD_W-1:0]  ord_t;

  // request kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ORDER = 3'd1;
  localparam logic [2:0] ST_NO_MEM    = 3'd2;
  localparam logic [2:0] ST_PAST_END  = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

  // per page bookkeeping word
  typedef struct packed {
    logic alloc;
    ord_t order;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  // memory port requests from the sequencer
  typedef struct packed {
    logic  we;
    page_t waddr;
    page_t wdata;
    page_t raddr;
  } link_req_t;

  typedef struct packed {
    logic  we;
    page_t waddr;
    meta_t wdata;
    page_t raddr;
  } meta_req_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_SRCH,
    S_PULL_RD,
    S_PULL_WR,
    S_PULL_ZERO,
    S_SPLIT,
    S_PUSH_A,
    S_PUSH_B,
    S_FREE_RD,
    S_FREE_CHK,
    S_MERGE_TST,
    S_MERGE_CHK,
    S_MERGE_UPD,
    S_INIT,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/bpa_if.sv -----
// handshake channels of the buddy page allocator
`timescale 1ns / 1ps
interface bpa_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  bpa_pkg::ord_t        order;
  bpa_pkg::page_t       page_number;
  modport source (output valid, kind, order, page_number, input ready);
  modport sink (input valid, kind, order, page_number, output ready);
endinterface

interface bpa_out_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  bpa_pkg::page_t       page_number_res;
  modport source (output valid, status, page_number_res, input ready);
  modport sink (input valid, status, page_number_res, output ready);
endinterface

interface bpa_cfg_if;
  logic                 valid;
  logic                 ready;
  bpa_pkg::page_t       data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/bpa_ram.sv -----
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bpa_seq.sv -----
// sequencer: list and page bookkeeping over the link and meta memories
`timescale 1ns / 1ps
module bpa_seq (
  input  logic                clk,
  input  logic                rst_n,
  bpa_in_if.sink              in_bus,
  bpa_out_if.source           out_bus,
  bpa_cfg_if.sink             cfg_bus,
  output bpa_pkg::link_req_t  prev_req,
  output bpa_pkg::link_req_t  next_req,
  output bpa_pkg::meta_req_t  meta_req,
  input  bpa_pkg::page_t      prev_rdata,
  input  bpa_pkg::page_t      next_rdata,
  input  bpa_pkg::meta_t      meta_rdata
);

  localparam bpa_pkg::page_t PAGE_MAX = bpa_pkg::PAGE_W'(bpa_pkg::NUM_PAGES - 1);
  localparam bpa_pkg::ord_t  ORD_TOP  = bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER);

  bpa_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  bpa_pkg::ord_t   ord_r, ord_nxt, cur_r, cur_nxt, tord_r, tord_nxt;
  bpa_pkg::page_t  pg_r, pg_nxt, mate_r, mate_nxt, tgt_r, tgt_nxt;
  bpa_pkg::page_t  clr_r, clr_nxt, ffp_r, res_r, res_nxt;
  logic [bpa_pkg::CNT_W-1:0] ipg_r, ipg_nxt;
  logic            init_r, init_nxt;
  logic [2:0]      status_r, status_nxt;
  logic [bpa_pkg::LISTS-1:0] nonempty_r, nonempty_nxt;
  bpa_pkg::page_t  head_r [bpa_pkg::LISTS];
  bpa_pkg::page_t  head_nxt [bpa_pkg::LISTS];
  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_status_r, out_status_nxt;
  bpa_pkg::page_t  out_res_r, out_res_nxt;

  logic            in_fire, out_free, in_bad_ord, in_past;
  logic            srch_hit, free_bad, merge_stop;
  bpa_pkg::ord_t   srch_ord, init_k;
  bpa_pkg::page_t  mate, tgt_head;

  assign in_bus.ready  = (state_r == bpa_pkg::S_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign in_fire       = in_bus.valid & in_bus.ready;
  assign out_free      = !out_valid_r || out_bus.ready;

  assign out_bus.valid           = out_valid_r;
  assign out_bus.status          = out_status_r;
  assign out_bus.page_number_res = out_res_r;

  // request checks on the incoming beat
  assign in_bad_ord = in_bus.order > ORD_TOP;
  assign in_past    = ({1'b0, in_bus.page_number} + (16'd1 << in_bus.order))
                      > bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES);

  // stored block checks
  assign free_bad   = !meta_rdata.alloc || (meta_rdata.order != ord_r);
  assign merge_stop = meta_rdata.alloc || (meta_rdata.order != ord_r);
  assign mate       = pg_r ^ (bpa_pkg::PAGE_W'(1) << ord_r);
  assign tgt_head   = head_r[tord_r];

  // smallest non-empty list at or above the request
  always_comb begin
    srch_hit = 1'b0;
    srch_ord = '0;
    for (int i = bpa_pkg::LISTS - 1; i >= 0; i--) begin
      if (nonempty_r[i] && (bpa_pkg::ORD_W'(i) >= ord_r)) begin
        srch_hit = 1'b1;
        srch_ord = bpa_pkg::ORD_W'(i);
      end
    end
  end

  // largest aligned block that fits at the init cursor
  always_comb begin
    init_k = '0;
    for (int k = 1; k <= bpa_pkg::TOP_ORDER; k++) begin
      if ((ipg_r[bpa_pkg::PAGE_W-1:0] & bpa_pkg::PAGE_W'((1 << k) - 1)) == '0 &&
          (ipg_r + bpa_pkg::CNT_W'(1 << k)) <= bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES)) begin
        init_k = bpa_pkg::ORD_W'(k);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpa_pkg::S_CLEAR: begin
        if (clr_r == PAGE_MAX) state_nxt = init_r ? bpa_pkg::S_INIT : bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_bus.kind)
            bpa_pkg::KIND_INIT:  state_nxt = bpa_pkg::S_CLEAR;
            bpa_pkg::KIND_ALLOC: state_nxt = in_bad_ord ? bpa_pkg::S_DONE : bpa_pkg::S_SRCH;
            bpa_pkg::KIND_FREE:  state_nxt = (in_bad_ord || in_past) ? bpa_pkg::S_DONE
                                                                     : bpa_pkg::S_FREE_RD;
            default:             state_nxt = bpa_pkg::S_DONE;
          endcase
        end
      end
      bpa_pkg::S_SRCH:      state_nxt = srch_hit ? bpa_pkg::S_PULL_RD : bpa_pkg::S_DONE;
      bpa_pkg::S_PULL_RD:   state_nxt = bpa_pkg::S_PULL_WR;
      bpa_pkg::S_PULL_WR:   state_nxt = bpa_pkg::S_PULL_ZERO;
      bpa_pkg::S_PULL_ZERO: state_nxt = ret_r;
      bpa_pkg::S_SPLIT:     state_nxt = (cur_r > ord_r) ? bpa_pkg::S_PUSH_A : bpa_pkg::S_DONE;
      bpa_pkg::S_PUSH_A:    state_nxt = nonempty_r[tord_r] ? bpa_pkg::S_PUSH_B : ret_r;
      bpa_pkg::S_PUSH_B:    state_nxt = ret_r;
      bpa_pkg::S_FREE_RD:   state_nxt = bpa_pkg::S_FREE_CHK;
      bpa_pkg::S_FREE_CHK:  state_nxt = free_bad ? bpa_pkg::S_DONE : bpa_pkg::S_MERGE_TST;
      bpa_pkg::S_MERGE_TST: state_nxt = (ord_r == ORD_TOP) ? bpa_pkg::S_PUSH_A
                                                           : bpa_pkg::S_MERGE_CHK;
      bpa_pkg::S_MERGE_CHK: state_nxt = merge_stop ? bpa_pkg::S_PUSH_A : bpa_pkg::S_PULL_RD;
      bpa_pkg::S_MERGE_UPD: state_nxt = bpa_pkg::S_MERGE_TST;
      bpa_pkg::S_INIT:      state_nxt = ipg_r[bpa_pkg::PAGE_W] ? bpa_pkg::S_DONE
                                                               : bpa_pkg::S_PUSH_A;
      bpa_pkg::S_DONE:      state_nxt = out_free ? bpa_pkg::S_IDLE : bpa_pkg::S_DONE;
      default:              state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    ret_nxt        = ret_r;
    ord_nxt        = ord_r;
    cur_nxt        = cur_r;
    tord_nxt       = tord_r;
    pg_nxt         = pg_r;
    mate_nxt       = mate_r;
    tgt_nxt        = tgt_r;
    clr_nxt        = clr_r;
    ipg_nxt        = ipg_r;
    init_nxt       = init_r;
    status_nxt     = status_r;
    res_nxt        = res_r;
    nonempty_nxt   = nonempty_r;
    head_nxt       = head_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_status_nxt = out_status_r;
    out_res_nxt    = out_res_r;
    prev_req       = '0;
    next_req       = '0;
    meta_req       = '0;
    unique case (state_r)
      // sweep every page back to allocated, order zero
      bpa_pkg::S_CLEAR: begin
        meta_req.we    = 1'b1;
        meta_req.waddr = clr_r;
        meta_req.wdata = '{alloc: 1'b1, order: '0};
        clr_nxt        = clr_r + 1'b1;
        nonempty_nxt   = '0;
      end
      bpa_pkg::S_IDLE: begin
        if (in_fire) begin
          ord_nxt    = in_bus.order;
          pg_nxt     = in_bus.page_number;
          status_nxt = bpa_pkg::ST_OK;
          res_nxt    = '0;
          case (in_bus.kind)
            bpa_pkg::KIND_INIT: begin
              init_nxt = 1'b1;
              clr_nxt  = '0;
              ipg_nxt  = {1'b0, ffp_r};
            end
            bpa_pkg::KIND_ALLOC: begin
              if (in_bad_ord) status_nxt = bpa_pkg::ST_BAD_ORDER;
            end
            bpa_pkg::KIND_FREE: begin
              if (in_bad_ord) status_nxt = bpa_pkg::ST_BAD_ORDER;
              else if (in_past) status_nxt = bpa_pkg::ST_PAST_END;
            end
            default: ;
          endcase
        end
      end
      bpa_pkg::S_SRCH: begin
        if (srch_hit) begin
          cur_nxt  = srch_ord;
          tord_nxt = srch_ord;
          tgt_nxt  = head_r[srch_ord];
          pg_nxt   = head_r[srch_ord];
          ret_nxt  = bpa_pkg::S_SPLIT;
        end else begin
          status_nxt = bpa_pkg::ST_NO_MEM;
        end
      end
      // unlink a block from its list
      bpa_pkg::S_PULL_RD: begin
        prev_req.raddr = tgt_r;
        next_req.raddr = tgt_r;
      end
      bpa_pkg::S_PULL_WR: begin
        if (prev_rdata == tgt_r) begin
          if (next_rdata == tgt_r) begin
            nonempty_nxt[tord_r] = 1'b0;
          end else begin
            head_nxt[tord_r] = next_rdata;
            prev_req.we      = 1'b1;
            prev_req.waddr   = next_rdata;
            prev_req.wdata   = next_rdata;
          end
        end else begin
          next_req.we    = 1'b1;
          next_req.waddr = prev_rdata;
          if (next_rdata == tgt_r) begin
            next_req.wdata = prev_rdata;
          end else begin
            next_req.wdata = next_rdata;
            prev_req.we    = 1'b1;
            prev_req.waddr = next_rdata;
            prev_req.wdata = prev_rdata;
          end
        end
        meta_req.we    = 1'b1;
        meta_req.waddr = tgt_r;
        meta_req.wdata = '{alloc: 1'b1, order: tord_r};
      end
      bpa_pkg::S_PULL_ZERO: begin
        prev_req.we    = 1'b1;
        prev_req.waddr = tgt_r;
        next_req.we    = 1'b1;
        next_req.waddr = tgt_r;
      end
      // hand back upper halves, then settle the allocated block
      bpa_pkg::S_SPLIT: begin
        if (cur_r > ord_r) begin
          cur_nxt  = cur_r - 1'b1;
          tord_nxt = cur_r - 1'b1;
          tgt_nxt  = pg_r + (bpa_pkg::PAGE_W'(1) << (cur_r - 1'b1));
          ret_nxt  = bpa_pkg::S_SPLIT;
        end else begin
          meta_req.we    = 1'b1;
          meta_req.waddr = pg_r;
          meta_req.wdata = '{alloc: 1'b1, order: ord_r};
          res_nxt        = pg_r;
        end
      end
      // link a block in at the head of its list
      bpa_pkg::S_PUSH_A: begin
        meta_req.we    = 1'b1;
        meta_req.waddr = tgt_r;
        meta_req.wdata = '{alloc: 1'b0, order: tord_r};
        prev_req.we    = 1'b1;
        prev_req.waddr = tgt_r;
        prev_req.wdata = tgt_r;
        next_req.we    = 1'b1;
        next_req.waddr = tgt_r;
        next_req.wdata = nonempty_r[tord_r] ? tgt_head : tgt_r;
        if (!nonempty_r[tord_r]) begin
          head_nxt[tord_r]     = tgt_r;
          nonempty_nxt[tord_r] = 1'b1;
        end
      end
      bpa_pkg::S_PUSH_B: begin
        prev_req.we      = 1'b1;
        prev_req.waddr   = tgt_head;
        prev_req.wdata   = tgt_r;
        head_nxt[tord_r] = tgt_r;
      end
      bpa_pkg::S_FREE_RD: begin
        meta_req.raddr = pg_r;
      end
      bpa_pkg::S_FREE_CHK: begin
        if (free_bad) begin
          status_nxt = bpa_pkg::ST_NOT_ALLOC;
        end else begin
          meta_req.we    = 1'b1;
          meta_req.waddr = pg_r;
          meta_req.wdata = '{alloc: 1'b0, order: ord_r};
        end
      end
      // look at the buddy one order up at a time
      bpa_pkg::S_MERGE_TST: begin
        if (ord_r == ORD_TOP) begin
          tgt_nxt  = pg_r;
          tord_nxt = ord_r;
          ret_nxt  = bpa_pkg::S_DONE;
        end else begin
          meta_req.raddr = mate;
          mate_nxt       = mate;
        end
      end
      bpa_pkg::S_MERGE_CHK: begin
        if (merge_stop) begin
          tgt_nxt  = pg_r;
          tord_nxt = ord_r;
          ret_nxt  = bpa_pkg::S_DONE;
        end else begin
          tgt_nxt  = mate_r;
          tord_nxt = ord_r;
          ret_nxt  = bpa_pkg::S_MERGE_UPD;
        end
      end
      bpa_pkg::S_MERGE_UPD: begin
        pg_nxt         = (mate_r < pg_r) ? mate_r : pg_r;
        ord_nxt        = ord_r + 1'b1;
        meta_req.we    = 1'b1;
        meta_req.waddr = (mate_r < pg_r) ? mate_r : pg_r;
        meta_req.wdata = '{alloc: 1'b0, order: ord_r + 1'b1};
      end
      // carve the free range into aligned blocks
      bpa_pkg::S_INIT: begin
        if (!ipg_r[bpa_pkg::PAGE_W]) begin
          tgt_nxt  = ipg_r[bpa_pkg::PAGE_W-1:0];
          tord_nxt = init_k;
          ret_nxt  = bpa_pkg::S_INIT;
          ipg_nxt  = ipg_r + (bpa_pkg::CNT_W'(1) << init_k);
        end
      end
      bpa_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_res_nxt    = res_r;
          init_nxt       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_CLEAR;
      clr_r       <= '0;
      init_r      <= 1'b0;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
      ffp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      init_r      <= init_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_bus.valid) ffp_r <= cfg_bus.data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ret_r        <= ret_nxt;
    ord_r        <= ord_nxt;
    cur_r        <= cur_nxt;
    tord_r       <= tord_nxt;
    pg_r         <= pg_nxt;
    mate_r       <= mate_nxt;
    tgt_r        <= tgt_nxt;
    ipg_r        <= ipg_nxt;
    status_r     <= status_nxt;
    res_r        <= res_nxt;
    head_r       <= head_nxt;
    out_status_r <= out_status_nxt;
    out_res_r    <= out_res_nxt;
  end

endmodule

// ----- hw/rtl/buddy_page_allocator_unit.sv -----
// Buddy page allocator over a 32768-page pool, block orders 0 to 11.
// Channels: in_bus takes one request beat (kind, order, page_number);
// out_bus returns one beat (status, page_number_res) per request;
// cfg_bus writes first_free_page; write it only while the block is idle,
// as the block itself does not enforce this (cfg_bus.ready is always high).
// Kinds: allocate, free, initialize pool. A fourth code answers ok, 0.
// Each merge level reads the buddy's meta word and links, then rewrites
// them.
// Initialize rewrites all 32768 page words, one per cycle, then links
// the free range in as aligned blocks, one block at a time.
// One request is worked at a time; in_bus.ready is high only when idle.
// The result register lets a new request enter while the last beat
// waits; a stalled out_bus holds the sequencer before its next result.
// Reset (rst_n low, synchronous) leaves every page allocated and all
// lists empty; it then sweeps the page memory, with in_bus.ready low,
// before the first request. Initialize is needed before any page can
// be allocated.
`timescale 1ns / 1ps
module buddy_page_allocator_unit (
  input  logic       clk,
  input  logic       rst_n,
  bpa_in_if.sink     in_bus,
  bpa_out_if.source  out_bus,
  bpa_cfg_if.sink    cfg_bus
);

  bpa_pkg::link_req_t prev_req, next_req;
  bpa_pkg::meta_req_t meta_req;
  bpa_pkg::page_t     prev_rdata, next_rdata;
  logic [bpa_pkg::META_W-1:0] meta_rdata;

  // request sequencer
  bpa_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_bus    (cfg_bus),
    .prev_req   (prev_req),
    .next_req   (next_req),
    .meta_req   (meta_req),
    .prev_rdata (prev_rdata),
    .next_rdata (next_rdata),
    .meta_rdata (bpa_pkg::meta_t'(meta_rdata))
  );

  // backward links
  bpa_ram #(.WIDTH(bpa_pkg::PAGE_W), .DEPTH(bpa_pkg::NUM_PAGES)) u_prev_ram (
    .clk   (clk),
    .we    (prev_req.we),
    .waddr (prev_req.waddr),
    .wdata (prev_req.wdata),
    .raddr (prev_req.raddr),
    .rdata (prev_rdata)
  );

  // forward links
  bpa_ram #(.WIDTH(bpa_pkg::PAGE_W), .DEPTH(bpa_pkg::NUM_PAGES)) u_next_ram (
    .clk   (clk),
    .we    (next_req.we),
    .waddr (next_req.waddr),
    .wdata (next_req.wdata),
    .raddr (next_req.raddr),
    .rdata (next_rdata)
  );

  // allocated mark and order per page
  bpa_ram #(.WIDTH(bpa_pkg::META_W), .DEPTH(bpa_pkg::NUM_PAGES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_req.we),
    .waddr (meta_req.waddr),
    .wdata (meta_req.wdata),
    .raddr (meta_req.raddr),
    .rdata (meta_rdata)
  );

endmodule

// ----- hw/rtl/bpa_checker.sv -----
// port level checks of the buddy page allocator and their bind
`timescale 1ns / 1ps
module bpa_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [2:0]           out_status,
  input bpa_pkg::page_t       out_res
);

  // a result beat stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // reset starts the page sweep, so no request is taken next
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken right after reset");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // only a successful allocate carries a page
  a_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bpa_pkg::ST_OK |-> out_res == '0)
    else $error("page returned with a fault status");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_status (out_bus.status),
  .out_res    (out_bus.page_number_res)
);

// ----- bench/buddy_page_allocator_unit_test.sv -----
// testbench of the buddy page allocator: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module buddy_page_allocator_unit_test;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int TIMEOUT_NS = 60_000_000;

  typedef struct packed {
    logic [2:0]     status;
    bpa_pkg::page_t page;
  } answer_t;

  typedef struct packed {
    bpa_pkg::page_t page;
    bpa_pkg::ord_t  order;
  } block_t;

  logic clk;
  logic rst_n;

  bpa_in_if  in_bus ();
  bpa_out_if out_bus ();
  bpa_cfg_if cfg_bus ();

  buddy_page_allocator_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // allocator shadow state
  bpa_pkg::page_t link_prev  [bpa_pkg::NUM_PAGES];
  bpa_pkg::page_t link_next  [bpa_pkg::NUM_PAGES];
  bpa_pkg::ord_t  blk_order  [bpa_pkg::NUM_PAGES];
  bit             blk_taken  [bpa_pkg::NUM_PAGES];
  bpa_pkg::page_t order_head [bpa_pkg::LISTS];
  bit             free_any   [bpa_pkg::LISTS];
  int             pool_start;

  answer_t answers_due[$];
  block_t  held_blocks[$];
  int      errors;
  int      tx_idle_pct;
  int      rx_idle_pct;
  bit      rx_hold;

  // clear every list and mark every page taken
  function automatic void shadow_clear();
    for (int i = 0; i < bpa_pkg::NUM_PAGES; i++) begin
      link_prev[i] = '0;
      link_next[i] = '0;
      blk_order[i] = '0;
      blk_taken[i] = 1'b1;
    end
    for (int k = 0; k < bpa_pkg::LISTS; k++) begin
      order_head[k] = '0;
      free_any[k]   = 1'b0;
    end
  endfunction

  // put a block on the front of its order list
  function automatic void shadow_push(int pg, int ord);
    if (pg >= bpa_pkg::NUM_PAGES || ord > bpa_pkg::TOP_ORDER) return;
    blk_order[pg] = bpa_pkg::ord_t'(ord);
    blk_taken[pg] = 1'b0;
    link_prev[pg] = bpa_pkg::page_t'(pg);
    if (free_any[ord]) begin
      link_next[pg] = order_head[ord];
      link_prev[order_head[ord]] = bpa_pkg::page_t'(pg);
    end else begin
      link_next[pg] = bpa_pkg::page_t'(pg);
    end
    order_head[ord] = bpa_pkg::page_t'(pg);
    free_any[ord] = 1'b1;
  endfunction

  // unlink a block from its order list and mark it taken
  function automatic void shadow_pull(int pg, int ord);
    int p;
    int n;
    p = link_prev[pg];
    n = link_next[pg];
    if (p == pg) begin
      if (n == pg) free_any[ord] = 1'b0;
      else begin
        order_head[ord] = bpa_pkg::page_t'(n);
        link_prev[n] = bpa_pkg::page_t'(n);
      end
    end else if (n == pg) begin
      link_next[p] = bpa_pkg::page_t'(p);
    end else begin
      link_next[p] = bpa_pkg::page_t'(n);
      link_prev[n] = bpa_pkg::page_t'(p);
    end
    link_prev[pg] = '0;
    link_next[pg] = '0;
    blk_taken[pg] = 1'b1;
  endfunction

  // carve the free range into the largest aligned blocks
  function automatic void pool_build();
    int pg;
    int k;
    shadow_clear();
    pg = pool_start;
    while (pg < bpa_pkg::NUM_PAGES) begin
      for (k = bpa_pkg::TOP_ORDER; k > 0; k--)
        if ((pg & ((1 << k) - 1)) == 0 && pg + (1 << k) <= bpa_pkg::NUM_PAGES) break;
      shadow_push(pg, k);
      pg += 1 << k;
    end
  endfunction

  // expected answer of one request, updating the shadow state
  function automatic answer_t allocator_answer(logic [1:0] kind, bpa_pkg::ord_t order,
                                               bpa_pkg::page_t page);
    answer_t a;
    int cur;
    int blk;
    int pg;
    int ord;
    int mate;
    a.status = bpa_pkg::ST_OK;
    a.page   = '0;
    ord = order;
    pg  = page;
    case (kind)
      bpa_pkg::KIND_INIT: begin
        pool_build();
        held_blocks.delete();
      end
      bpa_pkg::KIND_ALLOC: begin
        if (ord > bpa_pkg::TOP_ORDER) a.status = bpa_pkg::ST_BAD_ORDER;
        else begin
          cur = ord;
          while (cur <= bpa_pkg::TOP_ORDER && !free_any[cur]) cur++;
          if (cur > bpa_pkg::TOP_ORDER) a.status = bpa_pkg::ST_NO_MEM;
          else begin
            blk = order_head[cur];
            shadow_pull(blk, cur);
            while (cur > ord) begin
              cur--;
              shadow_push(blk + (1 << cur), cur);
            end
            blk_order[blk] = bpa_pkg::ord_t'(ord);
            blk_taken[blk] = 1'b1;
            a.page = bpa_pkg::page_t'(blk);
            held_blocks.push_back('{page: bpa_pkg::page_t'(blk), order: bpa_pkg::ord_t'(ord)});
          end
        end
      end
      bpa_pkg::KIND_FREE: begin
        if (ord > bpa_pkg::TOP_ORDER) a.status = bpa_pkg::ST_BAD_ORDER;
        else if (pg + (1 << ord) > bpa_pkg::NUM_PAGES) a.status = bpa_pkg::ST_PAST_END;
        else if (!blk_taken[pg] || blk_order[pg] != ord) a.status = bpa_pkg::ST_NOT_ALLOC;
        else begin
          for (int i = held_blocks.size() - 1; i >= 0; i--)
            if (held_blocks[i].page == pg) held_blocks.delete(i);
          blk_taken[pg] = 1'b0;
          while (ord < bpa_pkg::TOP_ORDER) begin
            mate = pg ^ (1 << ord);
            if (blk_taken[mate] || blk_order[mate] != ord) break;
            shadow_pull(mate, ord);
            if (mate < pg) pg = mate;
            ord++;
            blk_order[pg] = bpa_pkg::ord_t'(ord);
            blk_taken[pg] = 1'b0;
          end
          shadow_push(pg, ord);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // result receiver ready
  always @(negedge clk) begin
    if (!rst_n || rx_hold) out_bus.ready <= 1'b0;
    else out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result beat status %0d page %0d", $time,
                 out_bus.status, out_bus.page_number_res);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (out_bus.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_bus.status);
          errors++;
        end
        if (out_bus.page_number_res !== want.page) begin
          $display("%0t: page_number_res expected %0d actual %0d", $time, want.page,
                   out_bus.page_number_res);
          errors++;
        end
      end
    end
  end

  // send one request beat, then maybe idle
  task automatic send_request(logic [1:0] kind, bpa_pkg::ord_t order, bpa_pkg::page_t page);
    int gap;
    @(negedge clk);
    in_bus.valid       <= 1'b1;
    in_bus.kind        <= kind;
    in_bus.order       <= order;
    in_bus.page_number <= page;
    do @(posedge clk); while (!in_bus.ready);
    answers_due.push_back(allocator_answer(kind, order, page));
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(6, 1);
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop valid and wait until every answer has arrived
  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // write first_free_page while idle
  task automatic write_pool_start(bpa_pkg::page_t value);
    drain();
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    pool_start = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // requests on the pool left by reset
  task automatic test_pool_after_reset();
    send_request(bpa_pkg::KIND_ALLOC, 4'd0, '0);
    send_request(bpa_pkg::KIND_ALLOC, 4'd11, '0);
    send_request(bpa_pkg::KIND_FREE, 4'd0, 15'd5);
    send_request(bpa_pkg::KIND_FREE, 4'd0, 15'd4);
    send_request(bpa_pkg::KIND_FREE, 4'd1, 15'd4);
    send_request(bpa_pkg::KIND_ALLOC, 4'd0, '0);
    send_request(bpa_pkg::KIND_ALLOC, 4'd12, '0);
    send_request(bpa_pkg::KIND_FREE, 4'd15, 15'd7);
    send_request(KIND_UNUSED, 4'd15, 15'h7fff);
  endtask

  // single-page pool at the top end
  task automatic test_last_page_pool();
    write_pool_start(15'h7fff);
    send_request(bpa_pkg::KIND_INIT, 4'd15, 15'h7fff);
    send_request(bpa_pkg::KIND_ALLOC, 4'd1, '0);
    send_request(bpa_pkg::KIND_ALLOC, 4'd0, '0);
    send_request(bpa_pkg::KIND_ALLOC, 4'd0, '0);
    send_request(bpa_pkg::KIND_FREE, 4'd1, 15'h7fff);
    send_request(bpa_pkg::KIND_FREE, 4'd11, 15'h7801);
    send_request(bpa_pkg::KIND_FREE, 4'd0, 15'h7fff);
    send_request(bpa_pkg::KIND_FREE, 4'd0, 15'h7fff);
  endtask

  // whole pool: largest blocks, split and full merge back
  task automatic test_full_pool();
    write_pool_start('0);
    send_request(bpa_pkg::KIND_INIT, 4'd0, '0);
    send_request(bpa_pkg::KIND_ALLOC, 4'd11, '0);
    send_request(bpa_pkg::KIND_ALLOC, 4'd0, '0);
    send_request(bpa_pkg::KIND_ALLOC, 4'd0, '0);
    send_request(bpa_pkg::KIND_FREE, 4'd0, 15'd1);
    send_request(bpa_pkg::KIND_FREE, 4'd0, 15'd0);
    send_request(bpa_pkg::KIND_FREE, 4'd11, 15'h7800);
  endtask

  // mostly well formed alloc and free traffic with some noise
  task automatic test_random_traffic(bpa_pkg::page_t start, int count);
    int roll;
    int idx;
    block_t b;
    write_pool_start(start);
    send_request(bpa_pkg::KIND_INIT, 4'($urandom), 15'($urandom));
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        send_request(bpa_pkg::KIND_ALLOC, ($urandom_range(9) == 0) ? 4'($urandom) :
                     4'($urandom_range(3)), 15'($urandom));
      end else if (roll < 88 && held_blocks.size() != 0) begin
        idx = $urandom_range(held_blocks.size() - 1);
        b = held_blocks[idx];
        send_request(bpa_pkg::KIND_FREE, b.order, b.page);
      end else begin
        roll = $urandom_range(2);
        send_request((roll == 0) ? KIND_UNUSED :
                     ((roll == 1) ? bpa_pkg::KIND_FREE : bpa_pkg::KIND_ALLOC),
                     4'($urandom), 15'($urandom));
      end
    end
  endtask

  // receiver stalls long while requests keep coming
  task automatic test_result_backpressure();
    drain();
    rx_hold = 1'b1;
    fork
      begin
        for (int n = 0; n < 20; n++)
          send_request(bpa_pkg::KIND_ALLOC, 4'($urandom_range(2)), '0);
      end
      begin
        repeat (3000) @(posedge clk);
        rx_hold = 1'b0;
      end
    join
  endtask

  // stimulus sequence
  initial begin
    errors = 0;
    pool_start = 0;
    rx_hold = 1'b0;
    tx_idle_pct = 19;
    rx_idle_pct = 83;
    shadow_clear();
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.kind = bpa_pkg::KIND_ALLOC;
    in_bus.order = '0;
    in_bus.page_number = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_pool_after_reset();
    test_last_page_pool();
    test_full_pool();
    test_random_traffic(15'd32704, 650);
    tx_idle_pct = 83;
    rx_idle_pct = 19;
    test_random_traffic(15'd30001, 650);
    test_result_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(15'd0, 650);
    drain();
    repeat (100) @(posedge clk);

    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_if.sv
hw/rtl/bpa_ram.sv
hw/rtl/bpa_seq.sv
hw/rtl/buddy_page_allocator_unit.sv
hw/rtl/bpa_checker.sv
bench/buddy_page_allocator_unit_test.sv
